[sv/tkvd_pkg.sv]
package tkvd_pkg;

    // Keypad geometry.
    localparam int KEY_ROWS   = 6;
    localparam int KEY_COLS   = 7;
    localparam int BTN_W      = 60;
    localparam int BTN_H      = 50;
    localparam int BTN_GAP    = 3;
    localparam int PART_GAP   = 36;
    localparam int TOP_ORIGIN = 2;

    // Widths fixed by the field and register definitions.
    localparam int COORD_W  = 10;
    localparam int EDGE_W   = 11;
    localparam int MARGIN_W = 5;
    localparam int WAIT_W   = 4;
    localparam int RCNT_W   = 5;
    localparam int POS_W    = 3;
    localparam int CODE_W   = 7;
    localparam int CFG_W    = 5;

    // Saturation point of the release counter.
    localparam logic [RCNT_W-1:0] RCNT_MAX = '1;

    // Configuration register indexes.
    localparam logic REG_EDGE_MARGIN  = 1'b0;
    localparam logic REG_RELEASE_WAIT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST  = 5'd8;
    localparam logic [WAIT_W-1:0]   RELEASE_WAIT_RST = 4'd4;

    // Result event codes.
    localparam logic EV_PRESSED  = 1'b0;
    localparam logic EV_RELEASED = 1'b1;

    // Classified touch beat passed from the front end to the back end.
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } tok_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TALLY,
        BK_OUT
    } back_state_t;

    // Left edge of a button column.
    function automatic logic [EDGE_W-1:0] col_left(input int c);
        int v;
        v = BTN_GAP + c * (BTN_W + BTN_GAP) + ((c > 2) ? PART_GAP : 0);
        return EDGE_W'(v);
    endfunction

    // Top edge of a button row.
    function automatic logic [EDGE_W-1:0] row_top(input int r);
        int v;
        v = TOP_ORIGIN + r * (BTN_H + BTN_GAP);
        return EDGE_W'(v);
    endfunction

    // ASCII label of a button; zero where no button exists.
    function automatic logic [CODE_W-1:0] key_label(input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col);
        logic [CODE_W-1:0] lbl;
        case ({row, col})
            6'o00:   lbl = 7'h31;
            6'o01:   lbl = 7'h32;
            6'o02:   lbl = 7'h33;
            6'o10:   lbl = 7'h34;
            6'o11:   lbl = 7'h35;
            6'o12:   lbl = 7'h36;
            6'o20:   lbl = 7'h37;
            6'o21:   lbl = 7'h38;
            6'o22:   lbl = 7'h39;
            6'o30:   lbl = 7'h23;
            6'o31:   lbl = 7'h30;
            6'o32:   lbl = 7'h20;
            6'o40:   lbl = 7'h2B;
            6'o41:   lbl = 7'h2D;
            6'o42:   lbl = 7'h64;
            6'o50:   lbl = 7'h2A;
            6'o51:   lbl = 7'h2F;
            6'o52:   lbl = 7'h72;
            6'o53:   lbl = 7'h65;
            6'o54:   lbl = 7'h70;
            6'o55:   lbl = 7'h50;
            6'o56:   lbl = 7'h43;
            default: lbl = '0;
        endcase
        return lbl;
    endfunction

endpackage

[sv/tkvd_front.sv]
module tkvd_front (
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               pressed,
    input  logic [tkvd_pkg::COORD_W-1:0]       touch_x,
    input  logic [tkvd_pkg::COORD_W-1:0]       touch_y,
    input  logic [tkvd_pkg::MARGIN_W-1:0]      edge_margin,
    output logic                               push_valid,
    input  logic                               push_ready,
    output tkvd_pkg::tok_t                     push_tok
);

    logic [tkvd_pkg::EDGE_W-1:0] x_ext;
    logic [tkvd_pkg::EDGE_W-1:0] y_ext;
    logic [tkvd_pkg::EDGE_W-1:0] margin_ext;
    logic [tkvd_pkg::KEY_ROWS-1:0] row_ok;
    logic [tkvd_pkg::KEY_COLS-1:0] col_ok;
    logic hit;
    logic [tkvd_pkg::POS_W-1:0] hit_row;
    logic [tkvd_pkg::POS_W-1:0] hit_col;

    assign x_ext      = {{(tkvd_pkg::EDGE_W - tkvd_pkg::COORD_W){1'b0}}, touch_x};
    assign y_ext      = {{(tkvd_pkg::EDGE_W - tkvd_pkg::COORD_W){1'b0}}, touch_y};
    assign margin_ext = {{(tkvd_pkg::EDGE_W - tkvd_pkg::MARGIN_W){1'b0}}, edge_margin};

    // Range checks of each row band and each column band.
    always_comb begin
        for (int r = 0; r < tkvd_pkg::KEY_ROWS; r++) begin
            row_ok[r] = (tkvd_pkg::row_top(r) + margin_ext <= y_ext) &&
                        (y_ext <= tkvd_pkg::row_top(r) + tkvd_pkg::EDGE_W'(tkvd_pkg::BTN_H));
        end
        for (int c = 0; c < tkvd_pkg::KEY_COLS; c++) begin
            col_ok[c] = (tkvd_pkg::col_left(c) + margin_ext <= x_ext) &&
                        (x_ext <= tkvd_pkg::col_left(c) + tkvd_pkg::EDGE_W'(tkvd_pkg::BTN_W));
        end
    end

    // The first existing button in row-major order that holds the point wins.
    always_comb begin
        hit     = 1'b0;
        hit_row = '0;
        hit_col = '0;
        for (int r = tkvd_pkg::KEY_ROWS - 1; r >= 0; r--) begin
            for (int c = tkvd_pkg::KEY_COLS - 1; c >= 0; c--) begin
                if (row_ok[r] && col_ok[c] &&
                    (tkvd_pkg::key_label(tkvd_pkg::POS_W'(r), tkvd_pkg::POS_W'(c)) != '0)) begin
                    hit     = 1'b1;
                    hit_row = tkvd_pkg::POS_W'(r);
                    hit_col = tkvd_pkg::POS_W'(c);
                end
            end
        end
    end

    // Pressed beats that miss every button are dropped here.
    assign in_ready      = push_ready;
    assign push_valid    = in_valid && (!pressed || hit);
    assign push_tok.hit  = pressed;
    assign push_tok.row  = hit_row;
    assign push_tok.col  = hit_col;

endmodule

[sv/tkvd_queue.sv]
module tkvd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  tkvd_pkg::tok_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output tkvd_pkg::tok_t rd_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    tkvd_pkg::tok_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic do_wr, do_rd;

    assign wr_ready = (fill_reg != (PTR_W + 1)'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + 1'b1;
        end else if (!do_wr && do_rd) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/tkvd_back.sv]
module tkvd_back #(
    parameter int NUM_TRIES = 7
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [tkvd_pkg::WAIT_W-1:0]     release_wait,
    input  logic                            tok_valid,
    output logic                            tok_ready,
    input  tkvd_pkg::tok_t                  tok,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            event_res,
    output logic [tkvd_pkg::CODE_W-1:0]     key_code,
    output logic [tkvd_pkg::POS_W-1:0]      key_row,
    output logic [tkvd_pkg::POS_W-1:0]      key_col
);

    localparam int IDX_W = $clog2(NUM_TRIES);
    localparam int CNT_W = $clog2(NUM_TRIES + 1);
    localparam int KEY_W = 2 * tkvd_pkg::POS_W;

    tkvd_pkg::back_state_t state_reg, state_next;

    logic [KEY_W-1:0]  sample_reg [NUM_TRIES];
    logic              phase_reg, phase_next;
    logic [CNT_W-1:0]  sample_cnt_reg, sample_cnt_next;
    logic [tkvd_pkg::RCNT_W-1:0] rel_cnt_reg, rel_cnt_next;
    logic [KEY_W-1:0]  chosen_reg, chosen_next;
    logic [IDX_W-1:0]  tally_idx_reg, tally_idx_next;
    logic [CNT_W-1:0]  best_cnt_reg, best_cnt_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic              tie_reg, tie_next;
    logic              ev_reg, ev_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [tkvd_pkg::CODE_W-1:0] out_code_reg, out_code_next;

    logic pop;
    logic store_vote;
    logic set_full;
    logic [tkvd_pkg::RCNT_W-1:0] rel_inc;
    logic release_done;
    logic [KEY_W-1:0] cur_key;
    logic [NUM_TRIES-1:0] match_vec;
    logic first_seen;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] step_best_cnt;
    logic [KEY_W-1:0] step_best_key;
    logic step_tie;
    logic tally_last;

    assign tok_ready = (state_reg == tkvd_pkg::BK_IDLE);
    assign pop       = tok_valid && tok_ready;

    // Release counting while waiting for the finger to lift.
    assign rel_inc      = (rel_cnt_reg == tkvd_pkg::RCNT_MAX) ? rel_cnt_reg : rel_cnt_reg + 1'b1;
    assign release_done = (rel_inc >= ({1'b0, release_wait} + 1'b1));

    // Vote collection.
    assign store_vote = pop && !phase_reg && tok.hit;
    assign set_full   = (sample_cnt_reg == CNT_W'(NUM_TRIES - 1));

    // One stored vote is tallied per cycle: its count and whether it is a first occurrence.
    assign cur_key = sample_reg[tally_idx_reg];
    always_comb begin
        first_seen = 1'b1;
        for (int j = 0; j < NUM_TRIES; j++) begin
            match_vec[j] = (sample_reg[j] == cur_key);
            if ((IDX_W'(j) < tally_idx_reg) && match_vec[j]) begin
                first_seen = 1'b0;
            end
        end
    end
    assign cur_cnt    = CNT_W'($countones(match_vec));
    assign tally_last = (tally_idx_reg == IDX_W'(NUM_TRIES - 1));

    // Running best count; an equal count marks a tie until a higher one appears.
    always_comb begin
        step_best_cnt = best_cnt_reg;
        step_best_key = best_key_reg;
        step_tie      = tie_reg;
        if (first_seen) begin
            if (cur_cnt > best_cnt_reg) begin
                step_best_cnt = cur_cnt;
                step_best_key = cur_key;
                step_tie      = 1'b0;
            end else if (cur_cnt == best_cnt_reg) begin
                step_tie = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tkvd_pkg::BK_IDLE: begin
                if (pop) begin
                    if (phase_reg && !tok.hit && release_done) begin
                        state_next = tkvd_pkg::BK_OUT;
                    end else if (store_vote && set_full) begin
                        state_next = tkvd_pkg::BK_TALLY;
                    end
                end
            end
            tkvd_pkg::BK_TALLY: begin
                if (tally_last) begin
                    state_next = step_tie ? tkvd_pkg::BK_IDLE : tkvd_pkg::BK_OUT;
                end
            end
            tkvd_pkg::BK_OUT: begin
                if (out_ready) begin
                    state_next = tkvd_pkg::BK_IDLE;
                end
            end
            default: state_next = tkvd_pkg::BK_IDLE;
        endcase
    end

    // Datapath updates per state.
    always_comb begin
        phase_next      = phase_reg;
        sample_cnt_next = sample_cnt_reg;
        rel_cnt_next    = rel_cnt_reg;
        chosen_next     = chosen_reg;
        tally_idx_next  = tally_idx_reg;
        best_cnt_next   = best_cnt_reg;
        best_key_next   = best_key_reg;
        tie_next        = tie_reg;
        ev_next         = ev_reg;
        out_key_next    = out_key_reg;
        out_code_next   = out_code_reg;
        case (state_reg)
            tkvd_pkg::BK_IDLE: begin
                if (pop && phase_reg && !tok.hit) begin
                    if (release_done) begin
                        phase_next      = 1'b0;
                        sample_cnt_next = '0;
                        rel_cnt_next    = '0;
                        ev_next         = tkvd_pkg::EV_RELEASED;
                        out_key_next    = chosen_reg;
                        out_code_next   = tkvd_pkg::key_label(chosen_reg[KEY_W-1 -: tkvd_pkg::POS_W],
                                                              chosen_reg[tkvd_pkg::POS_W-1:0]);
                    end else begin
                        rel_cnt_next = rel_inc;
                    end
                end else if (store_vote) begin
                    sample_cnt_next = sample_cnt_reg + 1'b1;
                    tally_idx_next  = '0;
                    best_cnt_next   = '0;
                    best_key_next   = '0;
                    tie_next        = 1'b0;
                end
            end
            tkvd_pkg::BK_TALLY: begin
                best_cnt_next  = step_best_cnt;
                best_key_next  = step_best_key;
                tie_next       = step_tie;
                tally_idx_next = tally_idx_reg + 1'b1;
                if (tally_last) begin
                    sample_cnt_next = '0;
                    if (!step_tie) begin
                        chosen_next   = step_best_key;
                        phase_next    = 1'b1;
                        rel_cnt_next  = '0;
                        ev_next       = tkvd_pkg::EV_PRESSED;
                        out_key_next  = step_best_key;
                        out_code_next = tkvd_pkg::key_label(step_best_key[KEY_W-1 -: tkvd_pkg::POS_W],
                                                            step_best_key[tkvd_pkg::POS_W-1:0]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tkvd_pkg::BK_IDLE;
            phase_reg      <= 1'b0;
            sample_cnt_reg <= '0;
            rel_cnt_reg    <= '0;
            chosen_reg     <= '0;
            tally_idx_reg  <= '0;
            best_cnt_reg   <= '0;
            tie_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            sample_cnt_reg <= sample_cnt_next;
            rel_cnt_reg    <= rel_cnt_next;
            chosen_reg     <= chosen_next;
            tally_idx_reg  <= tally_idx_next;
            best_cnt_reg   <= best_cnt_next;
            tie_reg        <= tie_next;
        end
    end

    // Payload registers and vote storage.
    always_ff @(posedge aclk) begin
        best_key_reg <= best_key_next;
        ev_reg       <= ev_next;
        out_key_reg  <= out_key_next;
        out_code_reg <= out_code_next;
        if (store_vote) begin
            sample_reg[sample_cnt_reg[IDX_W-1:0]] <= {tok.row, tok.col};
        end
    end

    assign out_valid = (state_reg == tkvd_pkg::BK_OUT);
    assign event_res = ev_reg;
    assign key_code  = out_code_reg;
    assign key_row   = out_key_reg[KEY_W-1 -: tkvd_pkg::POS_W];
    assign key_col   = out_key_reg[tkvd_pkg::POS_W-1:0];

endmodule

[sv/touch_keypad_vote_decoder_core.sv]
// Channel   | Direction | Handshake         | Payload
// s_        | in        | s_valid / s_ready | s_pressed, s_touch_x, s_touch_y
// m_        | out       | m_valid / m_ready | m_event_res, m_key_code, m_key_row, m_key_col
// cfg_      | in        | cfg_wr_en         | cfg_index, cfg_wdata
//
// A beat is classified by the hit test in the cycle it is accepted and lands in a
// two-entry queue. The back end takes one queued beat per cycle when idle; the beat
// that completes a vote set starts a tally, one stored vote per cycle.
// A result waits in the output register until taken; the queue keeps accepting
// beats meanwhile and s_ready drops only when it is full.
// Synchronous active-low reset clears all control state and loads register defaults.
module touch_keypad_vote_decoder_core #(
    parameter int NUM_TRIES = 7
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_pressed,
    input  logic [tkvd_pkg::COORD_W-1:0]     s_touch_x,
    input  logic [tkvd_pkg::COORD_W-1:0]     s_touch_y,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_event_res,
    output logic [tkvd_pkg::CODE_W-1:0]      m_key_code,
    output logic [tkvd_pkg::POS_W-1:0]       m_key_row,
    output logic [tkvd_pkg::POS_W-1:0]       m_key_col,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [tkvd_pkg::CFG_W-1:0]       cfg_wdata
);

    logic [tkvd_pkg::MARGIN_W-1:0] edge_margin_reg;
    logic [tkvd_pkg::WAIT_W-1:0]   release_wait_reg;
    logic           push_valid, push_ready;
    tkvd_pkg::tok_t push_tok;
    logic           pop_valid, pop_ready;
    tkvd_pkg::tok_t pop_tok;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_margin_reg  <= tkvd_pkg::EDGE_MARGIN_RST;
            release_wait_reg <= tkvd_pkg::RELEASE_WAIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tkvd_pkg::REG_EDGE_MARGIN:  edge_margin_reg  <= cfg_wdata[tkvd_pkg::MARGIN_W-1:0];
                tkvd_pkg::REG_RELEASE_WAIT: release_wait_reg <= cfg_wdata[tkvd_pkg::WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tkvd_front u_front (
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .pressed     (s_pressed),
        .touch_x     (s_touch_x),
        .touch_y     (s_touch_y),
        .edge_margin (edge_margin_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_tok    (push_tok)
    );

    tkvd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_tok),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_tok)
    );

    tkvd_back #(
        .NUM_TRIES (NUM_TRIES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .release_wait (release_wait_reg),
        .tok_valid    (pop_valid),
        .tok_ready    (pop_ready),
        .tok          (pop_tok),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .event_res    (m_event_res),
        .key_code     (m_key_code),
        .key_row      (m_key_row),
        .key_col      (m_key_col)
    );

endmodule
